[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/brcq_pkg.sv]
// Types and constants of the bearer request coalescing queue.
package brcq_pkg;

  localparam int BRCQ_QUEUE_DEPTH = 8;
  localparam int BEARER_BITS      = 8;

  typedef struct packed {
    logic                   action;
    logic [BEARER_BITS-1:0] bearer_mask;
    logic                   want_on;
    logic                   completion_failed;
  } brcq_item_t;

  typedef struct packed {
    logic                   issue_valid;
    logic [BEARER_BITS-1:0] issue_bearer;
    logic                   issue_on;
    logic                   result_code;
    logic                   pending;
    logic [BEARER_BITS-1:0] current_status;
  } brcq_result_t;

  typedef struct packed {
    logic [BEARER_BITS-1:0] bearer;
    logic                   on;
    logic                   in_flight;
  } brcq_entry_t;

  localparam logic ACT_REQUEST    = 1'b0;
  localparam logic ACT_COMPLETION = 1'b1;

  localparam logic CODE_OK   = 1'b0;
  localparam logic CODE_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } brcq_state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } brcq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } brcq_sts_t;

endpackage

[hw/rtl/bearer_request_coalescing_queue_unit.sv]
// Bearer request coalescing queue: one result transaction per item transaction.
// The block takes one item at a time. Each item walks the stored queue once
// through an entry memory with one read and one write port, reading and
// compacting one entry per cycle; the queue holds at most QUEUE_DEPTH entries.
// An item is handled in steps: capture the item and update the status mask,
// walk the queue (memory reads, then a closing step once the reads are done),
// then append and load the result. The append step is held off for as long as
// an earlier result is still stalled in the output register. The result sits
// in that register, so the next item is accepted while it waits to be taken.
// No clearing pass runs after reset.
module bearer_request_coalescing_queue_unit import brcq_pkg::*; #(
  parameter int QUEUE_DEPTH = BRCQ_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  brcq_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output brcq_result_t result
);

  brcq_cmd_t cmd;
  brcq_sts_t sts;

  brcq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  brcq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

[hw/rtl/brcq_ctrl.sv]
// Sequencing state machine of the bearer request coalescing queue.
module brcq_ctrl import brcq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  brcq_sts_t sts,
  output brcq_cmd_t cmd
);

  brcq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.start  = item_valid;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/brcq_datapath.sv]
// Queue memory, compaction walk, status mask and result register.
`include "assert_macros.svh"

module brcq_datapath import brcq_pkg::*; #(
  parameter int QUEUE_DEPTH = BRCQ_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  brcq_cmd_t    cmd,
  output brcq_sts_t    sts,
  input  brcq_item_t   item,
  output brcq_result_t result,
  output logic         result_valid,
  input  logic         result_stall
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);

  brcq_entry_t            mem [QUEUE_DEPTH];
  brcq_entry_t            rd_data;
  logic                   rd_valid;
  logic [CW-1:0]          rd_ptr;
  logic [CW-1:0]          wr_ptr;
  logic [CW-1:0]          count;
  logic [BEARER_BITS-1:0] status;
  logic [BEARER_BITS-1:0] cur_bearer;
  logic                   cur_action;
  logic                   cur_on;
  logic                   found;
  logic                   handled;
  logic                   f_on;
  logic                   iss_valid;
  logic                   iss_on;

  logic                   rd_en;
  logic                   match;
  logic                   cur_st;
  logic                   keep;
  brcq_entry_t            walk_entry;
  logic                   found_next;
  logic                   handled_next;
  logic                   f_on_next;
  logic                   iss_valid_next;
  logic                   iss_on_next;
  logic                   need_app;
  logic                   full;
  logic                   app_ok;
  brcq_entry_t            app_entry;
  logic                   wr_en;
  brcq_entry_t            wr_data;
  logic [CW-1:0]          count_next;
  brcq_result_t           result_next;

  assign rd_en  = cmd.step && (rd_ptr < count);
  assign match  = (rd_data.bearer == cur_bearer);
  assign cur_st = |(status & cur_bearer);

  // One entry per walk step: keep it (possibly marked in flight) or drop it.
  always_comb begin
    keep           = 1'b1;
    walk_entry     = rd_data;
    found_next     = found;
    handled_next   = handled;
    f_on_next      = f_on;
    iss_valid_next = iss_valid;
    iss_on_next    = iss_on;
    if (cur_action == ACT_REQUEST) begin
      if (match && !found && rd_data.in_flight) begin
        found_next = 1'b1;
        f_on_next  = rd_data.on;
      end else if (match && found) begin
        keep = 1'b0;
      end
    end else begin
      if (match && !found && rd_data.in_flight) begin
        keep       = 1'b0;
        found_next = 1'b1;
      end else if (match && !handled) begin
        handled_next = 1'b1;
        if (rd_data.on != cur_st) begin
          walk_entry.in_flight = 1'b1;
          iss_valid_next       = 1'b1;
          iss_on_next          = rd_data.on;
        end else begin
          keep = 1'b0;
        end
      end
    end
  end

  // Append decision at the end of the walk; wr_ptr is the compacted count.
  always_comb begin
    if (cur_action == ACT_REQUEST) begin
      need_app = found ? (f_on != cur_on) : (cur_on != cur_st);
    end else begin
      need_app = 1'b0;
    end
    full                = (wr_ptr == CW'(QUEUE_DEPTH));
    app_ok              = need_app && !full;
    app_entry.bearer    = cur_bearer;
    app_entry.on        = cur_on;
    app_entry.in_flight = !found;
    count_next          = app_ok ? wr_ptr + CW'(1) : wr_ptr;
  end

  always_comb begin
    result_next = '0;
    if (cur_action == ACT_REQUEST) begin
      result_next.issue_valid = app_ok && !found;
      result_next.issue_on    = app_ok && !found && cur_on;
      result_next.result_code = (need_app && full) ? CODE_FULL : CODE_OK;
    end else begin
      result_next.issue_valid = iss_valid;
      result_next.issue_on    = iss_valid && iss_on;
      result_next.result_code = CODE_OK;
    end
    result_next.issue_bearer   = result_next.issue_valid ? cur_bearer : '0;
    result_next.pending        = (count_next != '0);
    result_next.current_status = status;
  end

  assign wr_en   = (cmd.step && rd_valid && keep) || (cmd.finish && app_ok);
  assign wr_data = cmd.finish ? app_entry : walk_entry;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr[AW-1:0]] <= wr_data;
    if (rd_en) rd_data <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      count    <= '0;
      status   <= '0;
    end else if (cmd.start) begin
      rd_valid <= 1'b0;
      if (item.action == ACT_COMPLETION && !item.completion_failed) begin
        status <= item.want_on ? (status | item.bearer_mask) : (status & ~item.bearer_mask);
      end
    end else if (cmd.step) begin
      rd_valid <= rd_en;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_action <= item.action;
      cur_bearer <= item.bearer_mask;
      cur_on     <= item.want_on;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      found      <= 1'b0;
      handled    <= 1'b0;
      f_on       <= 1'b0;
      iss_valid  <= 1'b0;
      iss_on     <= 1'b0;
    end else if (cmd.step) begin
      if (rd_en) rd_ptr <= rd_ptr + CW'(1);
      if (rd_valid) begin
        if (keep) wr_ptr <= wr_ptr + CW'(1);
        found     <= found_next;
        handled   <= handled_next;
        f_on      <= f_on_next;
        iss_valid <= iss_valid_next;
        iss_on    <= iss_on_next;
      end
    end
  end

  // Result register; the next item may be accepted while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) result <= result_next;
  end

  assign sts.walk_done = (rd_ptr == count) && !rd_valid;
  assign sts.out_free  = !result_valid || !result_stall;

  `ASSERT_IMPL(a_wr_behind_rd, clk, rst, cmd.step, wr_ptr <= rd_ptr)
  `ASSERT_IMPL(a_rd_in_range, clk, rst, cmd.step, rd_ptr <= count)
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_finish_loads, clk, rst, cmd.finish, result_valid && result.pending == (count != '0))

endmodule

[tb/brcq_checker.sv]
`timescale 1ns / 1ps
// Checker for the bearer request coalescing queue: predicts every result and compares it.
module brcq_checker import brcq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  brcq_item_t   item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  brcq_result_t result,
  output int           fail_count,
  output int           waiting,
  output int           checked
);

  brcq_entry_t            held[$];
  logic [BEARER_BITS-1:0] bearer_status;
  brcq_result_t           due_results[$];
  brcq_result_t           oldest;

  function automatic int find_flight(logic [BEARER_BITS-1:0] b);
    for (int i = 0; i < held.size(); i++)
      if (held[i].bearer == b && held[i].in_flight) return i;
    return -1;
  endfunction

  function automatic brcq_result_t coalesce_item(brcq_item_t it);
    brcq_result_t r;
    brcq_entry_t  e;
    int           f;
    logic         cur;
    r = '0;
    if (it.action == ACT_REQUEST) begin
      f = find_flight(it.bearer_mask);
      if (f >= 0) begin
        // purge later entries of this bearer, then buffer if the state differs
        for (int j = held.size() - 1; j > f; j--)
          if (held[j].bearer == it.bearer_mask) held.delete(j);
        if (held[f].on != it.want_on) begin
          if (held.size() >= BRCQ_QUEUE_DEPTH) begin
            r.result_code = CODE_FULL;
          end else begin
            e.bearer    = it.bearer_mask;
            e.on        = it.want_on;
            e.in_flight = 1'b0;
            held.push_back(e);
          end
        end
      end else begin
        cur = |(bearer_status & it.bearer_mask);
        if (it.want_on != cur) begin
          if (held.size() >= BRCQ_QUEUE_DEPTH) begin
            r.result_code = CODE_FULL;
          end else begin
            e.bearer    = it.bearer_mask;
            e.on        = it.want_on;
            e.in_flight = 1'b1;
            held.push_back(e);
            r.issue_valid  = 1'b1;
            r.issue_bearer = it.bearer_mask;
            r.issue_on     = it.want_on;
          end
        end
      end
    end else begin
      if (!it.completion_failed) begin
        if (it.want_on) bearer_status = bearer_status | it.bearer_mask;
        else bearer_status = bearer_status & ~it.bearer_mask;
      end
      f = find_flight(it.bearer_mask);
      if (f >= 0) held.delete(f);
      // first remaining entry of the bearer is started or dropped
      for (int i = 0; i < held.size(); i++) begin
        if (held[i].bearer == it.bearer_mask) begin
          cur = |(bearer_status & it.bearer_mask);
          if (held[i].on != cur) begin
            e = held[i];
            e.in_flight = 1'b1;
            held[i] = e;
            r.issue_valid  = 1'b1;
            r.issue_bearer = it.bearer_mask;
            r.issue_on     = e.on;
          end else begin
            held.delete(i);
          end
          break;
        end
      end
    end
    r.pending        = (held.size() != 0);
    r.current_status = bearer_status;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held.delete();
      due_results.delete();
      bearer_status = '0;
      waiting = 0;
    end else begin
      if (result_valid && !result_stall) begin
        checked++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result transaction %h", $realtime, result);
        end else begin
          oldest = due_results.pop_front();
          if (result.issue_valid !== oldest.issue_valid ||
              result.issue_bearer !== oldest.issue_bearer ||
              result.issue_on !== oldest.issue_on ||
              result.result_code !== oldest.result_code ||
              result.pending !== oldest.pending ||
              result.current_status !== oldest.current_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch issue %b/%h/%b code %b pending %b status %h,",
                        " expected issue %b/%h/%b code %b pending %b status %h"},
                       $realtime, result.issue_valid, result.issue_bearer, result.issue_on,
                       result.result_code, result.pending, result.current_status,
                       oldest.issue_valid, oldest.issue_bearer, oldest.issue_on,
                       oldest.result_code, oldest.pending, oldest.current_status);
          end
        end
      end
      if (item_valid && !item_stall) due_results.push_back(coalesce_item(item));
      waiting = due_results.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the bearer request coalescing queue: clock, reset, stimulus, verdict.
module testbench;
  import brcq_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  brcq_item_t   item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  brcq_result_t result;

  int fail_count, waiting, checked;
  int items_sent = 0;
  int issue_seen = 0;
  int full_seen  = 0;
  bit calm = 1'b0;

  logic [BEARER_BITS-1:0] pool [6];
  brcq_entry_t            started[$];   // operations the block started, fed back as completions

  bearer_request_coalescing_queue_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  brcq_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .checked      (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) begin
    result_stall <= !rst && !calm && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (result.issue_valid) begin
        issue_seen++;
        started.push_back({result.issue_bearer, result.issue_on, 1'b1});
        if (started.size() > 16) void'(started.pop_front());
      end
      if (result.result_code == CODE_FULL) full_seen++;
    end
  end

  function automatic brcq_item_t mk(logic act, logic [BEARER_BITS-1:0] b, logic on,
                                    logic failed);
    brcq_item_t it;
    it.action            = act;
    it.bearer_mask       = b;
    it.want_on           = on;
    it.completion_failed = failed;
    return it;
  endfunction

  // mostly requests on the pool and completions of started operations, some noise
  function automatic brcq_item_t random_item();
    brcq_item_t  it;
    brcq_entry_t e;
    int          pick;
    int          idx;
    pick = $urandom_range(99);
    if (pick < 8) begin
      it = brcq_item_t'($urandom);
    end else if (pick < 58 || started.size() == 0) begin
      it = mk(ACT_REQUEST, pool[$urandom_range(5)], 1'($urandom_range(1)),
              1'($urandom_range(1)));
      if ($urandom_range(9) == 0) it.bearer_mask = BEARER_BITS'($urandom);
    end else begin
      idx = $urandom_range(started.size() - 1);
      e = started[idx];
      started.delete(idx);
      it = mk(ACT_COMPLETION, e.bearer, e.on, $urandom_range(99) < 15);
      if ($urandom_range(9) == 0) it.want_on = ~it.want_on;
    end
    return it;
  endfunction

  task automatic send_item(brcq_item_t it);
    if (!calm && $urandom_range(99) < 26) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    brcq_item_t directed[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b1, 1'b0));    // started at once
    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b1, 1'b0));    // same as in flight
    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b0, 1'b0));    // buffered
    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b1, 1'b1));    // purges the buffered one
    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b0, 1'b0));
    directed.push_back(mk(ACT_COMPLETION, 8'h01, 1'b1, 1'b0)); // starts the buffered off
    directed.push_back(mk(ACT_COMPLETION, 8'h01, 1'b0, 1'b1)); // failed, mask kept
    directed.push_back(mk(ACT_REQUEST, 8'h01, 1'b1, 1'b0));    // already on
    directed.push_back(mk(ACT_REQUEST, 8'h00, 1'b0, 1'b0));    // zero mask, off dropped
    directed.push_back(mk(ACT_REQUEST, 8'h00, 1'b1, 1'b0));    // zero mask, on started
    directed.push_back(mk(ACT_COMPLETION, 8'h00, 1'b1, 1'b0));
    directed.push_back(mk(ACT_COMPLETION, 8'h80, 1'b1, 1'b0)); // no entries at all
    for (int k = 1; k <= 4; k++)
      directed.push_back(mk(ACT_REQUEST, 8'(1 << k), 1'b1, 1'b0));
    for (int k = 1; k <= 4; k++)
      directed.push_back(mk(ACT_REQUEST, 8'(1 << k), 1'b0, 1'b0));
    directed.push_back(mk(ACT_REQUEST, 8'hFF, 1'b0, 1'b0));    // queue full
    directed.push_back(mk(ACT_REQUEST, 8'h02, 1'b1, 1'b0));    // purge frees a slot
    directed.push_back(mk(ACT_REQUEST, 8'h02, 1'b0, 1'b0));
    directed.push_back(mk(ACT_REQUEST, 8'h20, 1'b1, 1'b0));    // full again
    directed.push_back(mk(ACT_COMPLETION, 8'h02, 1'b1, 1'b0));
    directed.push_back(mk(ACT_COMPLETION, 8'hFF, 1'b0, 1'b0)); // clears every bit
    foreach (directed[i]) send_item(directed[i]);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      for (int k = 0; k < 6; k++)
        pool[k] = (phase == 0) ? 8'(1 << k) : 8'($urandom);
      if (phase == 3) begin
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
      end
      calm = (phase == 2);
      for (int n = 0; n < 110; n++) send_item(random_item());
      if (phase == 1 || phase == 3) drain();
    end
    calm = 1'b0;

    drain();
    repeat (4 * (BRCQ_QUEUE_DEPTH + 4)) @(posedge clk);
    $display("Sent %0d items (%0d directed), checked %0d results, %0d operations started.",
             items_sent, directed.size(), checked, issue_seen);
    $display("Queue-full answers seen: %0d; one phase ran with no idling on either side.",
             full_seen);
    if (fail_count == 0 && waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
